// ===== src/iim_pkg.sv =====
`timescale 1ns / 1ps
package iim_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PUT_W    = $clog2(CAPACITY + 2);
    localparam int VAL_W    = 32;
    localparam int ENT_W    = 3 * VAL_W;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 40;

    typedef enum logic [1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PUT_B,
        ST_PUT_C,
        ST_FINAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic put_b;
        logic put_c;
        logic final_put;
        logic commit;
    } ctl_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

// ===== src/iim_ram.sv =====
`timescale 1ns / 1ps
module iim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/iim_ctrl.sv =====
`timescale 1ns / 1ps
module iim_ctrl
    import iim_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = stat.scan_done ? ST_FINAL : ST_EVAL;
            ST_EVAL:   state_next = ST_PUT_B;
            ST_PUT_B:  state_next = ST_PUT_C;
            ST_PUT_C:  state_next = ST_READ;
            ST_FINAL:  state_next = ST_COMMIT;
            ST_COMMIT: if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_EVAL:   ctl.eval      = 1'b1;
            ST_PUT_B:  ctl.put_b     = 1'b1;
            ST_PUT_C:  ctl.put_c     = 1'b1;
            ST_FINAL:  ctl.final_put = 1'b1;
            ST_COMMIT: ctl.commit    = stat.out_free;
            default:   ctl           = '0;
        endcase
    end

endmodule

// ===== src/iim_dp.sv =====
`timescale 1ns / 1ps
module iim_dp
    import iim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    output stat_t            stat,
    input  logic [IN_W-1:0]  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    cmd_t               cmd_reg;
    logic [VAL_W-1:0]   lo_reg, hi_reg, id_reg, lv_reg;
    logic               bank_reg;
    logic [CNT_W-1:0]   used_reg, idx_reg;
    logic [PUT_W-1:0]   n_reg;
    logic               placed_reg, hit_reg, pv_reg;
    logic [VAL_W-1:0]   found_reg, pl_reg, ph_reg, po_reg;
    logic               ov_reg, of_full_reg;
    logic [VAL_W-1:0]   of_found_reg;
    logic [COUNT_W-1:0] of_count_reg;

    logic [ENT_W-1:0]   rd0, rd1, cur;
    logic [VAL_W-1:0]   ent_l, ent_h, ent_o, rs, re;
    logic               below, above, overlap, need_a, need_b, need_c, merge;
    logic               put, we0, we1;
    logic [ENT_W-1:0]   wdata;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic               fits;

    assign rs    = in_data[33:2];
    assign re    = in_data[65:34];
    assign cur   = bank_reg ? rd1 : rd0;
    assign ent_l = cur[VAL_W-1:0];
    assign ent_h = cur[2*VAL_W-1:VAL_W];
    assign ent_o = cur[ENT_W-1:2*VAL_W];

    assign below   = ent_h < lo_reg;
    assign above   = ent_l > hi_reg;
    assign overlap = !below && !above;
    assign need_a  = overlap && (ent_l < lo_reg);
    assign need_b  = !placed_reg && (above || (overlap && ent_h > hi_reg));
    assign need_c  = below || above || (ent_h > hi_reg);
    assign merge   = pv_reg && (po_reg == ent_o) && (ph_reg != '1)
                     && ((ph_reg + 1'b1) == ent_l);
    assign fits    = n_reg <= PUT_W'(CAPACITY);

    always_comb
    begin
        put   = 1'b0;
        wdata = {po_reg, ph_reg, pl_reg};
        if (ctl.eval && cmd_reg == CMD_ASSIGN && need_a)
        begin
            put   = 1'b1;
            wdata = {ent_o, lo_reg - 1'b1, ent_l};
        end
        else if (ctl.eval && cmd_reg == CMD_COMPACT && !merge && pv_reg)
        begin
            put = 1'b1;
        end
        else if (ctl.put_b && cmd_reg == CMD_ASSIGN && need_b)
        begin
            put   = 1'b1;
            wdata = {id_reg, hi_reg, lo_reg};
        end
        else if (ctl.put_c && cmd_reg == CMD_ASSIGN && need_c)
        begin
            put   = 1'b1;
            wdata = {ent_o, ent_h, overlap ? hi_reg + 1'b1 : ent_l};
        end
        else if (ctl.final_put && cmd_reg == CMD_ASSIGN && !placed_reg)
        begin
            put   = 1'b1;
            wdata = {id_reg, hi_reg, lo_reg};
        end
        else if (ctl.final_put && cmd_reg == CMD_COMPACT && pv_reg)
        begin
            put = 1'b1;
        end
    end

    assign waddr = n_reg[ADDR_W-1:0];
    assign raddr = idx_reg[ADDR_W-1:0];
    assign we0   = put && (n_reg < PUT_W'(CAPACITY)) && bank_reg;
    assign we1   = put && (n_reg < PUT_W'(CAPACITY)) && !bank_reg;

    iim_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd0)
    );

    iim_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 1'b0;
            used_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                ov_reg <= 1'b1;
                if ((cmd_reg == CMD_ASSIGN && fits) || cmd_reg == CMD_COMPACT)
                begin
                    bank_reg <= !bank_reg;
                    used_reg <= CNT_W'(n_reg);
                end
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd_t'(in_data[1:0]);
            lo_reg     <= (rs < re) ? rs : re;
            hi_reg     <= (rs < re) ? re : rs;
            id_reg     <= in_data[97:66];
            lv_reg     <= in_data[129:98];
            placed_reg <= (in_data[97:66] == '0);
            idx_reg    <= '0;
            n_reg      <= '0;
            hit_reg    <= 1'b0;
            pv_reg     <= 1'b0;
        end
        else
        begin
            if (put && n_reg != PUT_W'(CAPACITY + 1))
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (ctl.put_b && cmd_reg == CMD_ASSIGN && need_b)
            begin
                placed_reg <= 1'b1;
            end
            if (ctl.put_c)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctl.eval && cmd_reg == CMD_LOOKUP && !hit_reg
                && lv_reg >= ent_l && lv_reg <= ent_h)
            begin
                hit_reg   <= 1'b1;
                found_reg <= ent_o;
            end
            if (ctl.eval && cmd_reg == CMD_COMPACT)
            begin
                if (merge)
                begin
                    ph_reg <= ent_h;
                end
                else
                begin
                    pl_reg <= ent_l;
                    ph_reg <= ent_h;
                    po_reg <= ent_o;
                    pv_reg <= 1'b1;
                end
            end
        end
        if (ctl.commit)
        begin
            of_found_reg <= (cmd_reg == CMD_LOOKUP && hit_reg) ? found_reg : '0;
            of_full_reg  <= (cmd_reg == CMD_ASSIGN) && !fits;
            if ((cmd_reg == CMD_ASSIGN && fits) || cmd_reg == CMD_COMPACT)
            begin
                of_count_reg <= COUNT_W'(n_reg);
            end
            else
            begin
                of_count_reg <= COUNT_W'(used_reg);
            end
        end
    end

    assign stat.scan_done = idx_reg == used_reg;
    assign stat.out_free  = !ov_reg || out_ready;
    assign out_valid      = ov_reg;
    assign out_data       = {of_count_reg, of_full_reg, of_found_reg};

endmodule

// ===== src/interval_id_map.sv =====
// interval_id_map: table of up to 64 non-overlapping 32-bit ranges with owner ids.
// Input beats on s_axis carry a command (assign, lookup, compact, nop) with
// the range ends, owner id and lookup value. Each beat yields one output beat
// on m_axis with the found id, a table-full flag and the entry count.
// Items are processed one at a time. The table sits in two RAM banks: each
// command scans the current bank, one stored entry at a time through the
// shared read address, and assign or compact writes the rebuilt table into
// the other bank before the banks swap. The block takes a new beat only
// once the result of the last one has been committed to the output register.
// A rejected assign leaves the bank select alone, so the table is unchanged.
// s_axis_tready is high only while no item is in work.
// Reset empties the table at once; no clearing pass over the RAMs is needed.
// A stalled m_axis holds its beat; the next item then waits in its last
// cycle until the pending beat is taken.
`timescale 1ns / 1ps
module interval_id_map
    import iim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0], range_start[33:2], range_end[65:34], owner_id[97:66],
    // lookup_value[129:98], zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // found_id[31:0], table_full[32], entry_count[39:33]
    output logic [OUT_W-1:0] m_axis_tdata
);

    ctl_t  ctl;
    stat_t stat;

    iim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    iim_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== src/iim_check.sv =====
`timescale 1ns / 1ps
module iim_check
    import iim_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0)
        else $error("rejected assign carries an id");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

endmodule

bind interval_id_map iim_check u_iim_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import iim_pkg::*;

    typedef struct {
        logic [31:0] found_id;
        logic        table_full;
        logic [6:0]  entry_count;
    } map_result_t;

    class range_table_scoreboard;
        logic [31:0] lo_q[$];
        logic [31:0] hi_q[$];
        logic [31:0] own_q[$];
        map_result_t pending[$];
        int          errors;
        int          checked;
        int          rejects;
        int          hits;

        function new();
            errors  = 0;
            checked = 0;
            rejects = 0;
            hits    = 0;
        endfunction

        function bit paint(logic [31:0] a, logic [31:0] b, logic [31:0] id);
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] nl[$];
            logic [31:0] nh[$];
            logic [31:0] no[$];
            bit          placed;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            placed = (id == 0);
            foreach (lo_q[i])
            begin
                if (hi_q[i] < lo)
                begin
                    nl.push_back(lo_q[i]); nh.push_back(hi_q[i]); no.push_back(own_q[i]);
                end
                else if (lo_q[i] > hi)
                begin
                    if (!placed)
                    begin
                        nl.push_back(lo); nh.push_back(hi); no.push_back(id);
                        placed = 1;
                    end
                    nl.push_back(lo_q[i]); nh.push_back(hi_q[i]); no.push_back(own_q[i]);
                end
                else
                begin
                    if (lo_q[i] < lo)
                    begin
                        nl.push_back(lo_q[i]); nh.push_back(lo - 32'd1); no.push_back(own_q[i]);
                    end
                    if (hi_q[i] > hi)
                    begin
                        if (!placed)
                        begin
                            nl.push_back(lo); nh.push_back(hi); no.push_back(id);
                            placed = 1;
                        end
                        nl.push_back(hi + 32'd1); nh.push_back(hi_q[i]); no.push_back(own_q[i]);
                    end
                end
            end
            if (!placed)
            begin
                nl.push_back(lo); nh.push_back(hi); no.push_back(id);
            end
            if (nl.size() > CAPACITY)
                return 0;
            lo_q = nl;
            hi_q = nh;
            own_q = no;
            return 1;
        endfunction

        function void merge_neighbors();
            int w;
            w = 0;
            foreach (lo_q[i])
            begin
                if (w > 0 && own_q[w-1] == own_q[i] && hi_q[w-1] != 32'hFFFF_FFFF
                    && hi_q[w-1] + 32'd1 == lo_q[i])
                begin
                    hi_q[w-1] = hi_q[i];
                end
                else
                begin
                    lo_q[w] = lo_q[i]; hi_q[w] = hi_q[i]; own_q[w] = own_q[i];
                    w++;
                end
            end
            while (lo_q.size() > w)
            begin
                void'(lo_q.pop_back()); void'(hi_q.pop_back()); void'(own_q.pop_back());
            end
        endfunction

        function void note_command(logic [IN_W-1:0] d);
            map_result_t r;
            cmd_t        c;
            c = cmd_t'(d[1:0]);
            r.found_id   = 0;
            r.table_full = 0;
            case (c)
                CMD_ASSIGN:
                    if (!paint(d[33:2], d[65:34], d[97:66]))
                    begin
                        r.table_full = 1;
                        rejects++;
                    end
                CMD_LOOKUP:
                    foreach (lo_q[i])
                        if (r.found_id == 0 && d[129:98] >= lo_q[i] && d[129:98] <= hi_q[i])
                        begin
                            r.found_id = own_q[i];
                            hits++;
                        end
                CMD_COMPACT: merge_neighbors();
                default: ;
            endcase
            r.entry_count = 7'(lo_q.size());
            pending.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            map_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.found_id)
            begin
                $error("found_id: expected %h, got %h", e.found_id, d[31:0]);
                errors++;
            end
            if (d[32] !== e.table_full)
            begin
                $error("table_full: expected %b, got %b", e.table_full, d[32]);
                errors++;
            end
            if (d[39:33] !== e.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", e.entry_count, d[39:33]);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 0;
    logic             rst_n = 0;
    logic             s_axis_tvalid = 0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    range_table_scoreboard sb;
    bit   calm = 0;
    bit   hold_off = 0;
    int   sent = 0;

    interval_id_map u_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    always @(posedge clk)
        if (!rst_n || hold_off)
            m_axis_tready <= 0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 31);

    function logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(4000);
        endcase
    endfunction

    task automatic send_beat(cmd_t c, logic [31:0] a, logic [31:0] b, logic [31:0] id,
                             logic [31:0] v);
        logic [IN_W-1:0] d;
        d = '0;
        d[1:0] = c; d[33:2] = a; d[65:34] = b; d[97:66] = id; d[129:98] = v;
        while (!calm && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_command(d);
        sent++;
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int k;
        logic [31:0] id;
        k = $urandom_range(99);
        id = ($urandom_range(9) == 0) ? 32'h0 :
             ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 4);
        if (k < 55)
            send_beat(CMD_ASSIGN, pick_value(), pick_value(), id, $urandom);
        else if (k < 90)
            send_beat(CMD_LOOKUP, $urandom, $urandom, $urandom, pick_value());
        else if (k < 97)
            send_beat(CMD_COMPACT, $urandom, $urandom, $urandom, $urandom);
        else
            send_beat(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_beat(CMD_LOOKUP, 0, 0, 0, 32'h0);
        send_beat(CMD_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
        send_beat(CMD_ASSIGN, 32'h0, 32'h10, 32'hFFFF_FFFF, 0);
        send_beat(CMD_ASSIGN, 32'h11, 32'h20, 32'hFFFF_FFFF, 0);
        send_beat(CMD_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF);
        send_beat(CMD_LOOKUP, 0, 0, 0, 32'h15);
        send_beat(CMD_COMPACT, 0, 0, 0, 0);
        send_beat(CMD_ASSIGN, 32'h8, 32'h9, 0, 0);
        send_beat(CMD_ASSIGN, 32'h5, 32'h5, 32'h7, 0);
        send_beat(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_LOOKUP, 0, 0, 0, 32'h8);
        send_beat(CMD_ASSIGN, 32'h0, 32'hFFFF_FFFF, 0, 0);
        for (int i = 0; i < 66; i++)
            send_beat(CMD_ASSIGN, 32'(i * 4), 32'(i * 4 + 1), 32'(i + 1), 0);
        send_beat(CMD_ASSIGN, 32'h1, 32'h1, 0, 0);
        send_beat(CMD_ASSIGN, 32'h0, 32'hFFFF_FFFF, 0, 0);
        stop_input();
        drain();
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_random();
                stop_input();
            end
        join
        drain();
        for (int i = 0; i < 1500; i++)
        begin
            calm = (i >= 600 && i < 750);
            if (i % 150 == 149)
                send_beat(CMD_ASSIGN, 0, 32'hFFFF_FFFF, 0, 0);
            else
                send_random();
        end
        calm = 0;
        stop_input();
        fork
            drain();
            begin
                repeat (2_000_000) @(posedge clk);
                $display("Mismatches found");
                $finish;
            end
        join_any
        repeat (300) @(posedge clk);
        $display("Covered %0d commands: %0d results, %0d lookup hits, %0d full rejects.",
                 sent, sb.checked, sb.hits, sb.rejects);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
src/iim_pkg.sv
src/iim_ram.sv
src/iim_ctrl.sv
src/iim_dp.sv
src/interval_id_map.sv
src/iim_check.sv
verif/tb.sv
